FILE: src/pwlm_pkg.sv
// Shared constants, breakpoint tables and job record for the piecewise-linear mapper.
// No dependencies; every other file of the block imports this package.
package pwlm_pkg;

  // Table and field sizes
  localparam int NUM_POINTS  = 10;
  localparam int SAMPLE_BITS = 12;
  localparam int IN_W        = 12;
  localparam int BP_W        = 13;
  localparam int OUT_W       = 12;
  localparam int IDX_W       = 4;
  localparam int PROD_W      = BP_W + OUT_W;

  // Queue between classifier and interpolator
  localparam int QUEUE_DEPTH_DEF = 4;

  // Back end: product stage, one stage per quotient bit, output register
  localparam int BACK_STAGES = OUT_W + 2;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // Breakpoints, strictly increasing
  localparam logic [BP_W-1:0] BP_TABLE [NUM_POINTS] = '{
    13'd0, 13'd500, 13'd1000, 13'd1500, 13'd2000,
    13'd2500, 13'd3000, 13'd3500, 13'd4000, 13'd4100
  };

  // Output value at each breakpoint
  localparam logic [OUT_W-1:0] VAL_TABLE [NUM_POINTS] = '{
    12'd1, 12'd20, 12'd60, 12'd120, 12'd250,
    12'd300, 12'd500, 12'd800, 12'd1200, 12'd2100
  };

  // Classified transaction handed from front end to back end
  typedef struct packed {
    logic [IDX_W-1:0] seg;      // upper breakpoint index
    logic [OUT_W-1:0] hi_out;   // output at upper breakpoint
    logic [BP_W-1:0]  gap;      // upper breakpoint minus sample, 0 if no interpolation
    logic [OUT_W-1:0] delta;    // magnitude of the output step over the segment
    logic [BP_W-1:0]  span;     // segment width, 1 if no interpolation
    logic             falling;  // output drops across the segment
  } pwlm_job_t;

endpackage

FILE: src/pwlm_in_if.sv
// Input channel of the piecewise-linear mapper: valid/ready plus one converter sample.
// Depends on pwlm_pkg.
interface pwlm_in_if import pwlm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] adc_reading;

  modport source (output valid, output adc_reading, input ready);
  modport sink   (input valid, input adc_reading, output ready);
endinterface

FILE: src/pwlm_out_if.sv
// Result channel of the piecewise-linear mapper: valid/ready plus mapped value and segment.
// Depends on pwlm_pkg.
interface pwlm_out_if import pwlm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] mapped_value;
  logic [IDX_W-1:0] segment_index;

  modport source (output valid, output mapped_value, output segment_index, input ready);
  modport sink   (input valid, input mapped_value, input segment_index, output ready);
endinterface

FILE: src/pwlm_classify.sv
// Front end: compares a sample against all breakpoints at once and builds the job record.
// Depends on pwlm_pkg (tables, pwlm_job_t).
module pwlm_classify import pwlm_pkg::*; (
  input  logic [IN_W-1:0] adc_reading,
  output pwlm_job_t       job
);

  logic [BP_W-1:0]       r;
  logic [NUM_POINTS-1:0] gt;
  logic [IDX_W-1:0]      idx;
  logic [BP_W-1:0]       hi_bp;
  logic [BP_W-1:0]       lo_bp;
  logic [OUT_W-1:0]      hi_out;
  logic [OUT_W-1:0]      lo_out;
  logic                  below;
  logic                  direct;
  logic                  falling;

  always_comb begin
    // Keep the used sample bits and compare against every breakpoint
    r = BP_W'(adc_reading[SAMPLE_BITS-1:0]);
    for (int i = 0; i < NUM_POINTS; i++) begin
      gt[i] = r > BP_TABLE[i];
    end

    // Pick the first inner breakpoint at or above the sample, else the last one
    idx = IDX_W'(NUM_POINTS - 1);
    for (int i = NUM_POINTS - 2; i >= 1; i--) begin
      if (!gt[i]) begin
        idx = IDX_W'(i);
      end
    end

    below  = !gt[0];
    hi_bp  = BP_TABLE[idx];
    lo_bp  = BP_TABLE[idx - 1'b1];
    hi_out = below ? VAL_TABLE[0] : VAL_TABLE[idx];
    lo_out = VAL_TABLE[idx - 1'b1];

    // Output taken straight from the table: clamps, exact hits, empty segments
    direct  = below || gt[NUM_POINTS-1] || (r == hi_bp) || (hi_bp <= lo_bp);
    falling = !direct && (hi_out < lo_out);

    job.seg     = below ? '0 : idx;
    job.hi_out  = hi_out;
    job.falling = falling;
    job.delta   = falling ? (lo_out - hi_out) : (hi_out - lo_out);
    job.gap     = direct ? '0 : (hi_bp - r);
    job.span    = direct ? BP_W'(1) : (hi_bp - lo_bp);
  end

endmodule

FILE: src/pwlm_queue.sv
// Small register queue that decouples the classifier from the interpolation pipeline.
// Depends on pwlm_pkg (pwlm_job_t).
module pwlm_queue import pwlm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  pwlm_job_t push_job,
  output logic      pop_valid,
  input  logic      pop_ready,
  output pwlm_job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pwlm_job_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_job    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store the incoming transaction
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: src/pwlm_interp.sv
// Back end: multiply, bit-per-stage restoring divide, and final offset from the upper output.
// Depends on pwlm_pkg (pwlm_job_t, widths).
module pwlm_interp import pwlm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  pwlm_job_t        job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] mapped_value,
  output logic [IDX_W-1:0] segment_index
);

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [OUT_W-1:0]  quo;
    logic [BP_W-1:0]   span;
    logic [OUT_W-1:0]  hi_out;
    logic              falling;
    logic [IDX_W-1:0]  seg;
  } pwlm_div_t;

  pwlm_div_t        st_r   [0:OUT_W];
  pwlm_div_t        st_nxt [0:OUT_W];
  logic [OUT_W:0]   v_r;
  logic             adv;
  logic             out_valid_r;
  logic [OUT_W-1:0] value_r;
  logic [OUT_W-1:0] value_nxt;
  logic [IDX_W-1:0] seg_r;
  logic [OUT_W:0]   sum;
  pwlm_div_t        fin;

  // Whole pipeline moves together unless the output register is held
  assign adv       = !out_valid_r || out_ready;
  assign job_ready = adv;

  always_comb begin
    // Product stage
    st_nxt[0].rem     = PROD_W'(job.gap) * PROD_W'(job.delta);
    st_nxt[0].quo     = '0;
    st_nxt[0].span    = job.span;
    st_nxt[0].hi_out  = job.hi_out;
    st_nxt[0].falling = job.falling;
    st_nxt[0].seg     = job.seg;

    // One quotient bit per stage, most significant first
    for (int k = 1; k <= OUT_W; k++) begin
      st_nxt[k] = st_r[k-1];
      if (st_r[k-1].rem >= (PROD_W'(st_r[k-1].span) << (OUT_W - k))) begin
        st_nxt[k].rem = st_r[k-1].rem - (PROD_W'(st_r[k-1].span) << (OUT_W - k));
        st_nxt[k].quo = st_r[k-1].quo | (OUT_W'(1) << (OUT_W - k));
      end
    end
  end

  // Apply the quotient to the upper output, saturating both ways
  always_comb begin
    fin = st_r[OUT_W];
    sum = {1'b0, fin.hi_out} + {1'b0, fin.quo};
    if (fin.falling) begin
      value_nxt = sum[OUT_W] ? OUT_MAX : sum[OUT_W-1:0];
    end else begin
      value_nxt = (fin.quo > fin.hi_out) ? '0 : (fin.hi_out - fin.quo);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[OUT_W-1:0], job_valid};
      out_valid_r <= v_r[OUT_W];
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= OUT_W; k++) begin
        st_r[k] <= st_nxt[k];
      end
      value_r <= value_nxt;
      seg_r   <= fin.seg;
    end
  end

  assign out_valid     = out_valid_r;
  assign mapped_value  = value_r;
  assign segment_index = seg_r;

endmodule

FILE: src/piecewise_linear_adc_mapper_unit.sv
// Top level of the piecewise-linear converter mapper: classifier, queue, interpolator.
// Depends on pwlm_pkg, pwlm_in_if, pwlm_out_if, pwlm_classify, pwlm_queue, pwlm_interp.
//
// Usage:
//   in_if carries one 12-bit converter sample per transaction (valid/ready).
//   out_if returns one transaction per sample, in order: the interpolated
//   mapped_value and the segment_index of the upper breakpoint used.
//   There are no configuration registers; the breakpoint table is built in.
// Pipeline and throughput:
//   An accepted sample waits in the queue, then passes one multiply stage,
//   twelve divide stages (one quotient bit each) and the output register.
//   While nothing stalls, one sample per cycle is accepted and one result per
//   cycle delivered, set by the divide pipeline.
// Reset:
//   Synchronous, active low. Empties the queue and clears all pipeline valids.
// Receiver stall:
//   While out_if.ready is low with a result waiting, the back-end pipeline
//   holds. Samples keep entering the queue until its QUEUE_DEPTH entries are
//   full, then in_if.ready drops until the pipeline moves again.
module piecewise_linear_adc_mapper_unit import pwlm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  pwlm_in_if.sink           in_if,
  pwlm_out_if.source        out_if
);

  pwlm_job_t front_job;
  pwlm_job_t q_head;
  logic      q_push_ready;
  logic      q_head_valid;
  logic      back_ready;

  // Classify each sample as it arrives
  pwlm_classify u_front (
    .adc_reading (in_if.adc_reading),
    .job         (front_job)
  );

  assign in_if.ready = q_push_ready;

  // Decouple front and back
  pwlm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_if.valid),
    .push_ready (q_push_ready),
    .push_job   (front_job),
    .pop_valid  (q_head_valid),
    .pop_ready  (back_ready),
    .pop_job    (q_head)
  );

  // Interpolate and deliver
  pwlm_interp u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (q_head_valid),
    .job_ready     (back_ready),
    .job           (q_head),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .mapped_value  (out_if.mapped_value),
    .segment_index (out_if.segment_index)
  );

endmodule

FILE: src/pwlm_checker.sv
// Port-level checker for the piecewise-linear mapper, bound to the top level.
// Depends on pwlm_pkg, pwlm_in_if, pwlm_out_if, piecewise_linear_adc_mapper_unit.
module pwlm_checker import pwlm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  pwlm_in_if.sink    in_if,
  pwlm_out_if.source out_if
);

  localparam int CAP   = QUEUE_DEPTH + BACK_STAGES;
  localparam int OUT_CW = $clog2(CAP + 2) + 1;

  logic [OUT_CW-1:0] outstanding_r;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;

  // Track transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding_r <= outstanding_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      outstanding_r <= outstanding_r - 1'b1;
    end
  end

  // No result without a sample behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> outstanding_r != '0)
    else $error("result shown with no sample outstanding");

  // Queue plus pipeline bound the items in flight
  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r <= OUT_CW'(CAP))
    else $error("more transactions in flight than storage allows");

  // Reset leaves no result showing
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result valid right after reset");

  // Value lies within its segment's outputs
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |->
      (out_if.segment_index <= IDX_W'(NUM_POINTS - 1)) &&
      ((out_if.segment_index == '0) ?
         (out_if.mapped_value == VAL_TABLE[0]) :
         ((out_if.mapped_value >= VAL_TABLE[out_if.segment_index - 1'b1]) &&
          (out_if.mapped_value <= VAL_TABLE[out_if.segment_index]))))
    else $error("mapped value outside its segment");

endmodule

bind piecewise_linear_adc_mapper_unit pwlm_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pwlm_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if)
);
